FILE: rtl/core/psmc_pkg.sv
// shared types and constants for the power squelch median calibration core
package psmc_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_WINDOWS_DEF = 16;

  localparam int ALPHA_W    = 17;
  localparam int THR_W      = 32;
  localparam int WCNT_W     = 5;
  localparam int WLEN_W     = 16;
  localparam int LEVEL_W    = 48;
  localparam int FRAC_W     = 16;
  localparam int CHUNK_W    = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h1_0000;
  localparam logic [THR_W-1:0]   MAG_LIMIT  = 32'h8000_0000;
  localparam logic [WCNT_W-1:0]  WCNT_RESET = 5'd16;
  localparam logic [WLEN_W-1:0]  WLEN_RESET = 16'd1024;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ALPHA      = 3'd0,
    REG_THRESHOLD  = 3'd1,
    REG_USE_CAL    = 3'd2,
    REG_WIN_COUNT  = 3'd3,
    REG_WIN_LENGTH = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_SAMPLE    = 1'b0,
    OP_CAL_START = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_MAG,
    ST_DIFF,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_STEP,
    ST_APPLY,
    ST_TRACK,
    ST_SEL_LOAD,
    ST_SEL_CAND,
    ST_SEL_SCAN,
    ST_SEL_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic wr_en;
    logic rd_en;
  } peak_ctrl_t;

endpackage

FILE: rtl/core/psmc_if.sv
// request, result and configuration channel interfaces
interface psmc_item_if import psmc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic signed [SAMPLE_BITS-1:0] sample_real;
  logic signed [SAMPLE_BITS-1:0] sample_imag;

  modport source (output valid, opcode, sample_real, sample_imag, input ready);
  modport sink   (input valid, opcode, sample_real, sample_imag, output ready);
endinterface

interface psmc_result_if import psmc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] level;
  logic             unmuted;
  logic [THR_W-1:0] threshold_now;
  logic             calibration_done;

  modport source (output valid, level, unmuted, threshold_now, calibration_done,
                  input ready);
  modport sink   (input valid, level, unmuted, threshold_now, calibration_done,
                  output ready);
endinterface

interface psmc_cfg_if import psmc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

FILE: rtl/core/psmc_mul.sv
// shared unsigned multiplier with registered product
module psmc_mul import psmc_pkg::*; #(
  parameter int OP_W = ALPHA_W
) (
  input  logic              clk,
  input  logic              en,
  input  logic [OP_W-1:0]   op_a,
  input  logic [OP_W-1:0]   op_b,
  output logic [2*OP_W-1:0] prod
);

  logic [2*OP_W-1:0] full;

  assign full = op_a * op_b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full;
    end
  end

endmodule

FILE: rtl/core/psmc_peak_mem.sv
// per-window peak store with valid bits and a registered read port
module psmc_peak_mem import psmc_pkg::*; #(
  parameter int DEPTH = MAX_WINDOWS_DEF,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  peak_ctrl_t       ctrl,
  input  logic [IDX_W-1:0] waddr,
  input  logic [THR_W-1:0] wdata,
  input  logic [IDX_W-1:0] raddr,
  output logic [THR_W-1:0] rdata
);

  logic [THR_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  // an entry not written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctrl.clear) begin
      valid <= '0;
    end else if (ctrl.wr_en) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rdata <= valid[raddr] ? mem[raddr] : '0;
    end
  end

endmodule

FILE: rtl/core/power_squelch_median_calibration_core.sv
// Power squelch with median-of-peaks threshold calibration.
//
// item carries requests: opcode 0 is a complex sample, opcode 1 starts a
// calibration (honored only while calibration is enabled). Every request gives
// exactly one result on result: the integer smoothed power, the squelch
// decision, the active threshold and the calibration-done flag. cfg writes
// the five registers by index; it is always ready and is meant to be used
// while no request is in flight.
// A sample goes through one shared multiplier in sequence: two squares, then
// alpha times the level error in three 16-bit slices. The sample that closes
// the last window also runs a median search over the stored peaks through the
// single read port of the peak memory.
// item is ready only when no request is in flight. The result waits in an
// output register; if the receiver stalls, the next request is still taken,
// and the sequencer holds its finished result until the register is free.
// Synchronous reset restores the register defaults, zeroes the level and the
// active threshold and ends any calibration.
module power_squelch_median_calibration_core import psmc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
  input logic           clk,
  input logic           rst,
  psmc_item_if.sink     item,
  psmc_result_if.source result,
  psmc_cfg_if.sink      cfg
);

  localparam int OP_W   = (SAMPLE_BITS > ALPHA_W) ? SAMPLE_BITS : ALPHA_W;
  localparam int PROD_W = 2 * OP_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int ACC_W  = LEVEL_W + 1;
  localparam int IDX_W  = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOWS + 1);
  localparam int CW     = (CNT_W > WCNT_W) ? CNT_W : WCNT_W;

  state_t state, state_next;

  // configuration
  logic [ALPHA_W-1:0] alpha;
  logic               use_cal;
  logic [WCNT_W-1:0]  win_count;
  logic [WLEN_W-1:0]  win_length;

  // filter and calibration state
  logic [LEVEL_W-1:0] smoothed_level;
  logic [THR_W-1:0]   active_threshold;
  logic               calibrating;
  logic [CNT_W-1:0]   window_index;
  logic [WLEN_W-1:0]  sample_in_window;

  // per-request working registers
  logic [SAMPLE_BITS-1:0] abs_re, abs_im;
  logic [PROD_W-1:0]      sq_a;
  logic [THR_W-1:0]       mag;
  logic [LEVEL_W-1:0]     diff;
  logic                   up;
  logic [ACC_W-1:0]       acc;
  logic [THR_W-1:0]       cand;
  logic [CNT_W-1:0]       sel_i, scan_j, lt_cnt, le_cnt;

  // output register
  logic             out_valid;
  logic [THR_W-1:0] out_level;
  logic             out_unmuted;
  logic [THR_W-1:0] out_thr;
  logic             out_done;

  // shared multiplier and peak memory hookup
  logic [OP_W-1:0]   mul_a, mul_b;
  logic              mul_en;
  logic [PROD_W-1:0] prod;
  peak_ctrl_t        peak_ctrl;
  logic [IDX_W-1:0]  peak_raddr;
  logic [THR_W-1:0]  peak_rdata;

  // combinational helpers
  logic                   accept_item, is_cal, load_out, item_ready;
  logic [SAMPLE_BITS-1:0] re_bits, im_bits, re_abs, im_abs;
  logic [CW-1:0]          wc_ext, max_ext, eff_ext;
  logic [CNT_W-1:0]       eff_count, sel_k, widx_inc;
  logic [THR_W-1:0]       lvl_int;
  logic [WLEN_W-1:0]      len_eff, sample_inc;
  logic                   win_wrap, cal_end, peak_hit, found;
  logic [SUM_W-1:0]       sq_sum;
  logic                   mag_sat;
  logic [LEVEL_W-1:0]     x_val;
  logic                   x_ge;
  logic [ALPHA_W-1:0]     alpha_wr;

  psmc_mul #(.OP_W(OP_W)) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  psmc_peak_mem #(.DEPTH(MAX_WINDOWS), .IDX_W(IDX_W)) u_peak_mem (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (peak_ctrl),
    .waddr (window_index[IDX_W-1:0]),
    .wdata (lvl_int),
    .raddr (peak_raddr),
    .rdata (peak_rdata)
  );

  assign accept_item = item.valid && item_ready;
  assign is_cal      = (opcode_t'(item.opcode) == OP_CAL_START);
  assign load_out    = (state == ST_DONE) && (!out_valid || result.ready);

  assign re_bits = item.sample_real;
  assign im_bits = item.sample_imag;
  assign re_abs  = re_bits[SAMPLE_BITS-1] ? (~re_bits + SAMPLE_BITS'(1)) : re_bits;
  assign im_abs  = im_bits[SAMPLE_BITS-1] ? (~im_bits + SAMPLE_BITS'(1)) : im_bits;

  // window count clamped to 1..MAX_WINDOWS
  assign wc_ext    = CW'(win_count);
  assign max_ext   = CW'(MAX_WINDOWS);
  assign eff_ext   = (wc_ext == '0) ? CW'(1) : ((wc_ext > max_ext) ? max_ext : wc_ext);
  assign eff_count = eff_ext[CNT_W-1:0];
  assign sel_k     = eff_count >> 1;

  assign lvl_int    = smoothed_level[LEVEL_W-1:FRAC_W];
  assign len_eff    = (win_length == '0) ? WLEN_W'(1) : win_length;
  assign sample_inc = sample_in_window + WLEN_W'(1);
  assign win_wrap   = (sample_inc >= len_eff);
  assign widx_inc   = window_index + CNT_W'(win_wrap);
  assign cal_end    = (widx_inc >= eff_count);
  assign peak_hit   = (lvl_int >= peak_rdata);
  assign found      = (lt_cnt <= sel_k) && (sel_k < le_cnt);

  assign sq_sum  = SUM_W'(sq_a) + SUM_W'(prod);
  assign mag_sat = (sq_sum > SUM_W'(MAG_LIMIT));
  assign x_val   = {mag, {FRAC_W{1'b0}}};
  assign x_ge    = (x_val >= smoothed_level);

  assign alpha_wr = cfg.data[ALPHA_W-1:0];

  assign item.ready = item_ready;
  assign cfg.ready  = 1'b1;

  assign result.valid            = out_valid;
  assign result.level            = out_level;
  assign result.unmuted          = out_unmuted;
  assign result.threshold_now    = out_thr;
  assign result.calibration_done = out_done;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_item) begin
          state_next = is_cal ? ST_DONE : ST_SQ_A;
        end
      end
      ST_SQ_A:  state_next = ST_SQ_B;
      ST_SQ_B:  state_next = ST_MAG;
      ST_MAG:   state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_MUL0;
      ST_MUL0:  state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_STEP;
      ST_STEP:  state_next = ST_APPLY;
      ST_APPLY: state_next = (use_cal && calibrating) ? ST_TRACK : ST_DONE;
      ST_TRACK: state_next = cal_end ? ST_SEL_LOAD : ST_DONE;
      ST_SEL_LOAD: state_next = ST_SEL_CAND;
      ST_SEL_CAND: state_next = ST_SEL_SCAN;
      ST_SEL_SCAN: begin
        if (scan_j == eff_count) begin
          state_next = ST_SEL_CHECK;
        end
      end
      ST_SEL_CHECK: state_next = found ? ST_DONE : ST_SEL_LOAD;
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item_ready      = 1'b0;
    mul_en          = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    peak_ctrl       = '0;
    peak_raddr      = '0;
    case (state)
      ST_IDLE: begin
        item_ready      = 1'b1;
        peak_ctrl.clear = item.valid && is_cal && use_cal;
      end
      ST_SQ_A: begin
        mul_en = 1'b1;
        mul_a  = OP_W'(abs_re);
        mul_b  = OP_W'(abs_re);
      end
      ST_SQ_B: begin
        mul_en = 1'b1;
        mul_a  = OP_W'(abs_im);
        mul_b  = OP_W'(abs_im);
      end
      ST_MUL0: begin
        mul_en = 1'b1;
        mul_a  = OP_W'(alpha);
        mul_b  = OP_W'(diff[0 +: CHUNK_W]);
      end
      ST_MUL1: begin
        mul_en = 1'b1;
        mul_a  = OP_W'(alpha);
        mul_b  = OP_W'(diff[CHUNK_W +: CHUNK_W]);
      end
      ST_MUL2: begin
        mul_en = 1'b1;
        mul_a  = OP_W'(alpha);
        mul_b  = OP_W'(diff[2*CHUNK_W +: CHUNK_W]);
      end
      ST_APPLY: begin
        peak_ctrl.rd_en = use_cal && calibrating;
        peak_raddr      = window_index[IDX_W-1:0];
      end
      ST_TRACK: begin
        peak_ctrl.wr_en = peak_hit;
      end
      ST_SEL_LOAD: begin
        peak_ctrl.rd_en = 1'b1;
        peak_raddr      = sel_i[IDX_W-1:0];
      end
      ST_SEL_CAND: begin
        peak_ctrl.rd_en = 1'b1;
      end
      ST_SEL_SCAN: begin
        peak_ctrl.rd_en = (scan_j != eff_count);
        peak_raddr      = scan_j[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      alpha            <= ALPHA_ONE;
      use_cal          <= 1'b0;
      win_count        <= WCNT_RESET;
      win_length       <= WLEN_RESET;
      smoothed_level   <= '0;
      active_threshold <= '0;
      calibrating      <= 1'b0;
      window_index     <= '0;
      sample_in_window <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept_item && is_cal && use_cal) begin
            window_index     <= '0;
            sample_in_window <= '0;
            calibrating      <= 1'b1;
          end
        end
        ST_APPLY: begin
          // step never exceeds the error, so the level does not overshoot
          if (up) begin
            smoothed_level <= smoothed_level + acc[LEVEL_W-1:0];
          end else begin
            smoothed_level <= smoothed_level - acc[LEVEL_W-1:0];
          end
        end
        ST_TRACK: begin
          sample_in_window <= win_wrap ? '0 : sample_inc;
          window_index     <= widx_inc;
        end
        ST_SEL_CHECK: begin
          if (found) begin
            active_threshold <= cand;
            calibrating      <= 1'b0;
          end
        end
        default: begin
        end
      endcase

      if (cfg.valid) begin
        case (cfg_reg_t'(cfg.addr))
          REG_ALPHA:      alpha <= (alpha_wr > ALPHA_ONE) ? ALPHA_ONE : alpha_wr;
          REG_THRESHOLD:  active_threshold <= cfg.data[THR_W-1:0];
          REG_USE_CAL:    use_cal <= cfg.data[0];
          REG_WIN_COUNT:  win_count <= cfg.data[WCNT_W-1:0];
          REG_WIN_LENGTH: win_length <= cfg.data[WLEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept_item) begin
          abs_re <= re_abs;
          abs_im <= im_abs;
        end
      end
      ST_SQ_B: sq_a <= prod;
      ST_MAG:  mag <= mag_sat ? MAG_LIMIT : sq_sum[THR_W-1:0];
      ST_DIFF: begin
        up   <= x_ge;
        diff <= x_ge ? (x_val - smoothed_level) : (smoothed_level - x_val);
      end
      // floor(alpha * diff / 2^16) built from three 16-bit slices of diff
      ST_MUL1: acc <= ACC_W'(prod >> FRAC_W);
      ST_MUL2: acc <= acc + ACC_W'(prod);
      ST_STEP: acc <= acc + (ACC_W'(prod) << CHUNK_W);
      ST_TRACK: sel_i <= '0;
      ST_SEL_CAND: begin
        cand   <= peak_rdata;
        scan_j <= CNT_W'(1);
        lt_cnt <= '0;
        le_cnt <= '0;
      end
      ST_SEL_SCAN: begin
        // candidate is the median when its rank range covers count/2
        lt_cnt <= lt_cnt + CNT_W'(peak_rdata < cand);
        le_cnt <= le_cnt + CNT_W'(peak_rdata <= cand);
        if (scan_j != eff_count) begin
          scan_j <= scan_j + CNT_W'(1);
        end
      end
      ST_SEL_CHECK: sel_i <= sel_i + CNT_W'(1);
      default: begin
      end
    endcase

    if (load_out) begin
      out_level   <= lvl_int;
      out_unmuted <= (lvl_int >= active_threshold);
      out_thr     <= active_threshold;
      out_done    <= !calibrating;
    end
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the done state");

  a_step_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) |-> (acc <= ACC_W'(diff)))
    else $error("iir step larger than level error");

  a_window_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && calibrating) |-> (window_index < CNT_W'(MAX_WINDOWS)))
    else $error("window index past peak store while calibrating");

  a_median_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEL_LOAD) |-> (sel_i < eff_count))
    else $error("median search ran past the last window");

endmodule

FILE: bench/squelch_report_checker.sv
// predicts squelch reports from accepted requests and compares them with the result channel
module squelch_report_checker import psmc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  psmc_item_if   item,
  psmc_result_if result,
  psmc_cfg_if    cfg,
  output int     mismatches,
  output int     reports_owed
);

  localparam int PEAK_SLOTS = MAX_WINDOWS_DEF;

  typedef struct packed {
    logic [THR_W-1:0] level;
    logic             unmuted;
    logic [THR_W-1:0] threshold_now;
    logic             calibration_done;
  } squelch_report_t;

  // register copies
  logic [ALPHA_W-1:0] alpha_reg;
  logic [THR_W-1:0]   manual_thr;
  logic               cal_enable;
  logic [WCNT_W-1:0]  window_total;
  logic [WLEN_W-1:0]  window_span;

  // block state
  logic [LEVEL_W-1:0] power_level;
  logic [THR_W-1:0]   window_top [PEAK_SLOTS];
  logic [WCNT_W-1:0]  window_pos;
  logic [WLEN_W-1:0]  window_fill;
  logic               calibrating;
  logic [THR_W-1:0]   active_thr;

  squelch_report_t owed_reports[$];

  function automatic logic [15:0] magnitude(input logic [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

  task automatic restore_defaults();
    alpha_reg    = ALPHA_ONE;
    manual_thr   = '0;
    cal_enable   = 1'b0;
    window_total = WCNT_RESET;
    window_span  = WLEN_RESET;
    power_level  = '0;
    foreach (window_top[i]) window_top[i] = '0;
    window_pos   = '0;
    window_fill  = '0;
    calibrating  = 1'b0;
    active_thr   = '0;
  endtask

  task automatic apply_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_t'(addr))
      REG_ALPHA:      alpha_reg = data[ALPHA_W-1:0];
      REG_THRESHOLD: begin
        manual_thr = data[THR_W-1:0];
        active_thr = data[THR_W-1:0];
      end
      REG_USE_CAL:    cal_enable = data[0];
      REG_WIN_COUNT:  window_total = data[WCNT_W-1:0];
      REG_WIN_LENGTH: window_span = data[WLEN_W-1:0];
      default: ;
    endcase
  endtask

  // sorts the peaks of the first n windows in place and takes the middle one
  function automatic logic [THR_W-1:0] median_peak(input int n);
    logic [THR_W-1:0] t;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j + 1 < n - i; j++) begin
        if (window_top[j] > window_top[j+1]) begin
          t = window_top[j];
          window_top[j] = window_top[j+1];
          window_top[j+1] = t;
        end
      end
    end
    return window_top[n/2];
  endfunction

  task automatic smooth_power(input logic [15:0] re, input logic [15:0] im);
    logic [15:0]        a;
    logic [15:0]        b;
    logic [32:0]        pwr;
    logic [LEVEL_W-1:0] target;
    logic [LEVEL_W-1:0] diff;
    logic [ALPHA_W-1:0] gain;
    logic [64:0]        prod;
    a = magnitude(re);
    b = magnitude(im);
    pwr = 33'(a) * 33'(a) + 33'(b) * 33'(b);
    if (pwr > 33'(MAG_LIMIT)) pwr = 33'(MAG_LIMIT);
    target = {pwr[31:0], 16'h0000};
    gain = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    // step truncates toward the old level, so no overshoot
    if (target >= power_level) begin
      diff = target - power_level;
      prod = 65'(gain) * 65'(diff);
      power_level = power_level + prod[63:16];
    end else begin
      diff = power_level - target;
      prod = 65'(gain) * 65'(diff);
      power_level = power_level - prod[63:16];
    end
  endtask

  task automatic track_peaks();
    int                n;
    logic [WLEN_W-1:0] span;
    logic [THR_W-1:0]  lvl;
    n = (window_total == 0) ? 1 : ((window_total > PEAK_SLOTS) ? PEAK_SLOTS : window_total);
    span = (window_span == 0) ? WLEN_W'(1) : window_span;
    lvl = power_level[LEVEL_W-1:FRAC_W];
    if (window_pos < PEAK_SLOTS && lvl >= window_top[window_pos]) window_top[window_pos] = lvl;
    window_fill = window_fill + 16'd1;
    if (window_fill >= span) begin
      window_pos = window_pos + 5'd1;
      window_fill = '0;
    end
    // a shrunken window count ends the run here too
    if (window_pos >= n) begin
      active_thr = median_peak(n);
      calibrating = 1'b0;
    end
  endtask

  task automatic predict_report(input logic op, input logic [15:0] re, input logic [15:0] im);
    squelch_report_t rep;
    if (opcode_t'(op) == OP_CAL_START) begin
      if (cal_enable) begin
        foreach (window_top[i]) window_top[i] = '0;
        window_pos = '0;
        window_fill = '0;
        calibrating = 1'b1;
      end
    end else begin
      smooth_power(re, im);
      if (cal_enable && calibrating) track_peaks();
    end
    rep.level = power_level[LEVEL_W-1:FRAC_W];
    rep.unmuted = power_level >= {active_thr, 16'h0000};
    rep.threshold_now = active_thr;
    rep.calibration_done = !calibrating;
    owed_reports.push_back(rep);
  endtask

  task automatic compare_report();
    squelch_report_t want;
    if (owed_reports.size() == 0) begin
      $display("%0t: result with no request outstanding, level %0d threshold %0d",
               $time, result.level, result.threshold_now);
      mismatches++;
    end else begin
      want = owed_reports.pop_front();
      if (result.level !== want.level) begin
        $display("%0t: level expected %0d got %0d", $time, want.level, result.level);
        mismatches++;
      end
      if (result.unmuted !== want.unmuted) begin
        $display("%0t: unmuted expected %0b got %0b", $time, want.unmuted, result.unmuted);
        mismatches++;
      end
      if (result.threshold_now !== want.threshold_now) begin
        $display("%0t: threshold_now expected %0d got %0d", $time, want.threshold_now,
                 result.threshold_now);
        mismatches++;
      end
      if (result.calibration_done !== want.calibration_done) begin
        $display("%0t: calibration_done expected %0b got %0b", $time, want.calibration_done,
                 result.calibration_done);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restore_defaults();
      owed_reports.delete();
      mismatches = 0;
    end else begin
      if (cfg.valid && cfg.ready) apply_write(cfg.addr, cfg.data);
      if (result.valid && result.ready) compare_report();
      if (item.valid && item.ready) predict_report(item.opcode, item.sample_real, item.sample_imag);
    end
    reports_owed = owed_reports.size();
  end

endmodule

FILE: bench/tb_top.sv
// stimulus, clock, reset and verdict for the power squelch median calibration core
module tb_top import psmc_pkg::*;;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 750;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   mismatches;
  int   reports_owed;
  bit   sender_gaps = 1'b1;
  bit   ready_steady = 1'b0;
  int   ready_hold = 0;
  int   random_sent = 0;
  logic [WCNT_W-1:0] tb_count = WCNT_RESET;
  logic [WLEN_W-1:0] tb_len = WLEN_RESET;

  psmc_item_if   item_ch ();
  psmc_result_if res_ch ();
  psmc_cfg_if    cfg_ch ();

  power_squelch_median_calibration_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  squelch_report_checker report_check (
    .clk          (clk),
    .rst          (rst),
    .item         (item_ch),
    .result       (res_ch),
    .cfg          (cfg_ch),
    .mismatches   (mismatches),
    .reports_owed (reports_owed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // receiver back-pressure: mostly ready, short stalls, now and then a long one
  always @(negedge clk) begin : ready_gen
    int pick;
    if (ready_steady) begin
      res_ch.ready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        res_ch.ready <= 1'b1;
        ready_hold <= $urandom_range(0, 20);
      end else if (pick < 90) begin
        res_ch.ready <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        res_ch.ready <= 1'b0;
        ready_hold <= $urandom_range(8, 40);
      end
    end
  end

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_req(input opcode_t op, input logic [15:0] re, input logic [15:0] im);
    int g;
    g = sender_gaps ? gap_len() : 0;
    if (g > 0) begin
      item_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.opcode <= op;
    item_ch.sample_real <= re;
    item_ch.sample_imag <= im;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
  endtask

  task automatic idle_sender();
    item_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // hold requests until every outstanding report is back
  task automatic settle();
    idle_sender();
    while (reports_owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_WIN_COUNT) tb_count = val[WCNT_W-1:0];
    if (idx == REG_WIN_LENGTH) tb_len = val[WLEN_W-1:0];
    @(negedge clk);
  endtask

  function automatic logic [15:0] random_component(input int shift);
    logic signed [15:0] v;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return 16'h8000;
    if (pick < 8) return 16'h7FFF;
    v = 16'($urandom);
    return v >>> shift;
  endfunction

  function automatic logic [31:0] pick_alpha();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 32'd0;
    if (pick < 25) return 32'(ALPHA_ONE);
    if (pick < 32) return $urandom_range(65537, 131071);
    return $urandom_range(1, 65535);
  endfunction

  function automatic logic [31:0] pick_threshold();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) return 32'd0;
    if (pick < 18) return 32'(MAG_LIMIT);
    if (pick < 24) return $urandom;
    return $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 31);
  endfunction

  function automatic logic [31:0] pick_window_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 32'd0;
    if (pick < 8) return 32'd65535;
    return $urandom_range(1, 6);
  endfunction

  initial begin : stimulus
    int n_samples;
    int amp;
    int pick;
    int eff_count;
    int eff_len;

    item_ch.valid = 1'b0;
    item_ch.opcode = OP_SAMPLE;
    item_ch.sample_real = '0;
    item_ch.sample_imag = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = REG_ALPHA;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: no smoothing, zero threshold, calibration off
    send_req(OP_SAMPLE, 16'h0000, 16'h0000);
    send_req(OP_SAMPLE, 16'h7FFF, 16'h7FFF);
    send_req(OP_SAMPLE, 16'h8000, 16'h8000);
    send_req(OP_SAMPLE, 16'h8000, 16'h7FFF);
    send_req(OP_SAMPLE, 16'h0001, 16'hFFFF);
    send_req(OP_CAL_START, 16'hFFFF, 16'hFFFF);

    // frozen filter, then alpha above one saturates
    settle();
    write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(REG_ALPHA, 32'd0);
    send_req(OP_SAMPLE, 16'd100, 16'd100);
    settle();
    write_reg(REG_ALPHA, 32'd131071);
    write_reg(REG_THRESHOLD, 32'(MAG_LIMIT));
    send_req(OP_SAMPLE, 16'h8000, 16'h8000);
    send_req(OP_SAMPLE, 16'h0000, 16'h0000);
    settle();
    write_reg(REG_ALPHA, 32'd1);
    send_req(OP_SAMPLE, 16'h7FFF, 16'h8000);
    settle();
    write_reg(REG_ALPHA, 32'd32768);
    send_req(OP_SAMPLE, 16'hFFFF, 16'hFFFF);
    send_req(OP_SAMPLE, 16'd12345, 16'hA460);

    // zero window count and zero window length both act as one
    settle();
    write_reg(REG_ALPHA, 32'(ALPHA_ONE));
    write_reg(REG_USE_CAL, 32'd1);
    write_reg(REG_WIN_COUNT, 32'd0);
    write_reg(REG_WIN_LENGTH, 32'd0);
    send_req(OP_CAL_START, 16'h0000, 16'h0000);
    send_req(OP_SAMPLE, 16'd300, 16'd400);

    // calibration switched off halfway keeps the done flag low
    settle();
    write_reg(REG_WIN_COUNT, 32'd2);
    write_reg(REG_WIN_LENGTH, 32'd1);
    send_req(OP_CAL_START, 16'h0000, 16'h0000);
    send_req(OP_SAMPLE, 16'd10, 16'd0);
    settle();
    write_reg(REG_USE_CAL, 32'd0);
    send_req(OP_SAMPLE, 16'd20, 16'd0);
    settle();
    write_reg(REG_USE_CAL, 32'd1);
    send_req(OP_SAMPLE, 16'd30, 16'd0);

    // count above the peak store, then shrunk under the current window
    settle();
    write_reg(REG_WIN_COUNT, 32'd31);
    send_req(OP_CAL_START, 16'h0000, 16'h0000);
    send_req(OP_SAMPLE, 16'd500, 16'hFE00);
    send_req(OP_SAMPLE, 16'h9000, 16'd7);
    settle();
    write_reg(REG_WIN_COUNT, 32'd2);
    send_req(OP_SAMPLE, 16'd2000, 16'd2000);

    while (random_sent < RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(0, 3);
      sender_gaps = (pick != 0);
      ready_steady = (pick == 0);
      if ($urandom_range(0, 1)) write_reg(REG_ALPHA, pick_alpha());
      if ($urandom_range(0, 1)) write_reg(REG_THRESHOLD, pick_threshold());
      if ($urandom_range(0, 2) == 0) write_reg(REG_USE_CAL, 32'($urandom_range(0, 99) < 85));
      if ($urandom_range(0, 1)) begin
        if ($urandom_range(0, 9) == 0) write_reg(REG_WIN_COUNT, $urandom_range(0, 31));
        else write_reg(REG_WIN_COUNT, $urandom_range(1, 16));
      end
      if ($urandom_range(0, 1)) write_reg(REG_WIN_LENGTH, pick_window_length());

      eff_count = (tb_count == 0) ? 1 : ((tb_count > 16) ? 16 : tb_count);
      eff_len = (tb_len == 0) ? 1 : tb_len;
      n_samples = (eff_len > 96) ? 96 : eff_count * eff_len;
      if (n_samples > 96) n_samples = 96;
      n_samples += $urandom_range(0, 6);
      amp = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);

      if ($urandom_range(0, 99) < 80) begin
        send_req(OP_CAL_START, 16'($urandom), 16'($urandom));
        random_sent++;
      end
      for (int k = 0; k < n_samples; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) settle();
        if (pick >= 97) send_req(OP_CAL_START, 16'($urandom), 16'($urandom));
        else send_req(OP_SAMPLE, random_component(amp), random_component(amp));
        random_sent++;
      end
    end

    settle();
    repeat (400) @(negedge clk);
    if (mismatches == 0 && reports_owed == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
